FILE: design/base24_key_text_to_binary_macros.svh
// assertion macros shared by the checker of the base-24 key encoder
// no dependencies; included by the checker file
`ifndef BASE24_KEY_TEXT_TO_BINARY_MACROS_SVH
`define BASE24_KEY_TEXT_TO_BINARY_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define B24K_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b24k assertion failed");

// next-cycle implication, disabled while reset is asserted
`define B24K_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b24k assertion failed");

`endif

FILE: design/b24k_pkg.sv
// constants and helpers for the base-24 key text encoder
// no dependencies; imported by the top level and its checker
`default_nettype none

package b24k_pkg;

  localparam int unsigned ALPHA_LEN = 24;

  typedef logic [15:0] char_t;
  typedef logic [4:0]  digit_t;
  typedef logic [127:0] acc_t;

  localparam char_t CHAR_END  = 16'h0000;
  localparam char_t CHAR_DASH = 16'h002D;
  localparam char_t CHAR_N    = 16'h004E;

  // key alphabet, index is the digit value
  localparam char_t ALPHABET [ALPHA_LEN] = '{
    16'h0042, 16'h0043, 16'h0044, 16'h0046, 16'h0047, 16'h0048,
    16'h004A, 16'h004B, 16'h004D, 16'h0050, 16'h0051, 16'h0052,
    16'h0054, 16'h0056, 16'h0057, 16'h0058, 16'h0059, 16'h0032,
    16'h0033, 16'h0034, 16'h0036, 16'h0037, 16'h0038, 16'h0039
  };

  // bit of byte 14 that flags an n marker
  localparam int unsigned N_FLAG_BIT = 51;

  typedef struct packed {
    logic   hit;
    digit_t value;
  } digit_lookup_t;

  function automatic digit_lookup_t digit_of(input char_t c);
    digit_lookup_t res;
    res.hit   = 1'b0;
    res.value = '0;
    for (int j = 0; j < ALPHA_LEN; j++) begin
      if (ALPHABET[j] == c) begin
        res.hit   = 1'b1;
        res.value = digit_t'(j);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/base24_key_text_to_binary.sv
// base-24 key text encoder: characters in, two 64-bit words per key out
// depends on b24k_pkg
//
// Usage:
//  - input channel (in_valid/in_ready) takes one 16-bit character per request,
//    in_is_final marks the last character of a key
//  - each digit character within the key updates the 128-bit accumulator in the cycle it is taken:
//    the multiply by 24 is two shifted copies and one wide add
//  - one character per cycle is taken unless a final one waits; a final
//    request loads a two-word result stage; the state clears for the next key
//  - result channel (out_valid/out_ready) gives word 0 (bytes 0..7) then
//    word 1 (bytes 8..15, out_end_of_run high), first word in the cycle after
//    the final request is taken
//  - while the receiver stalls, non-final characters are still taken; a
//    final character waits only if the result stage cannot be emptied by
//    the end of the current cycle
//  - reset (rst_n low, synchronous) clears the scan state and empties the
//    result stage
`default_nettype none

module base24_key_text_to_binary
  import b24k_pkg::*;
#(
  parameter int unsigned KEY_DIGITS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_char_code,
  input  wire logic        in_is_final,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_word_value,
  output logic             out_word_index,
  output logic             out_end_of_run,
  output logic             out_status,
  output logic             out_has_n
);

  // scan state
  acc_t   acc_r, acc_nxt;
  digit_t count_r, count_nxt;
  digit_t npos_r, npos_nxt;
  logic   nseen_r, nseen_nxt;
  logic   bad_r, bad_nxt;
  logic   ended_r, ended_nxt;

  // result stage
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic        st_r, st_nxt;
  logic        hn_r, hn_nxt;
  logic        busy_r, busy_nxt;
  logic        sel_r, sel_nxt;

  // per-character update
  acc_t          acc_upd;
  digit_t        count_upd;
  digit_t        npos_upd;
  logic          nseen_upd;
  logic          bad_upd;
  logic          ended_upd;
  digit_lookup_t look;
  logic          skip;
  logic          in_take;
  logic          out_take;
  logic          final_take;
  logic          hn_upd;
  logic [63:0]   hi_marked;

  assign out_take   = out_valid && out_ready;
  assign in_ready   = !busy_r || (out_ready && sel_r) || !in_is_final;
  assign in_take    = in_valid && in_ready;
  assign final_take = in_take && in_is_final;

  assign look = digit_of(in_char_code);
  assign skip = ended_r || bad_r || (count_r >= digit_t'(KEY_DIGITS));

  always_comb begin
    acc_upd   = acc_r;
    count_upd = count_r;
    npos_upd  = npos_r;
    nseen_upd = nseen_r;
    bad_upd   = bad_r;
    ended_upd = ended_r;
    if (!skip) begin
      if (in_char_code == CHAR_END) begin
        ended_upd = 1'b1;
      end else if (in_char_code == CHAR_DASH) begin
        acc_upd = acc_r;
      end else if (in_char_code == CHAR_N) begin
        npos_upd  = count_r;
        nseen_upd = 1'b1;
      end else if (look.hit) begin
        // acc * 24 + digit, wraps at 2^128
        acc_upd   = (acc_r << 4) + (acc_r << 3) + acc_t'(look.value);
        count_upd = count_r + digit_t'(1);
      end else begin
        bad_upd = 1'b1;
      end
    end
  end

  assign hn_upd = !bad_upd && nseen_upd;

  always_comb begin
    hi_marked             = acc_upd[127:64];
    hi_marked[N_FLAG_BIT] = 1'b1;
    hi_marked[63:56]      = {3'b000, npos_upd};
  end

  always_comb begin
    acc_nxt   = acc_r;
    count_nxt = count_r;
    npos_nxt  = npos_r;
    nseen_nxt = nseen_r;
    bad_nxt   = bad_r;
    ended_nxt = ended_r;
    if (in_take) begin
      if (in_is_final) begin
        acc_nxt   = '0;
        count_nxt = '0;
        npos_nxt  = '0;
        nseen_nxt = 1'b0;
        bad_nxt   = 1'b0;
        ended_nxt = 1'b0;
      end else begin
        acc_nxt   = acc_upd;
        count_nxt = count_upd;
        npos_nxt  = npos_upd;
        nseen_nxt = nseen_upd;
        bad_nxt   = bad_upd;
        ended_nxt = ended_upd;
      end
    end
  end

  always_comb begin
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    st_nxt   = st_r;
    hn_nxt   = hn_r;
    busy_nxt = busy_r;
    sel_nxt  = sel_r;
    if (out_take) begin
      if (sel_r) begin
        busy_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
    // a final request is only taken when the stage is free by now
    if (final_take) begin
      lo_nxt   = acc_upd[63:0];
      hi_nxt   = hn_upd ? hi_marked : acc_upd[127:64];
      st_nxt   = bad_upd;
      hn_nxt   = hn_upd;
      busy_nxt = 1'b1;
      sel_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      count_r <= '0;
      npos_r  <= '0;
      nseen_r <= 1'b0;
      bad_r   <= 1'b0;
      ended_r <= 1'b0;
      busy_r  <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      count_r <= count_nxt;
      npos_r  <= npos_nxt;
      nseen_r <= nseen_nxt;
      bad_r   <= bad_nxt;
      ended_r <= ended_nxt;
      busy_r  <= busy_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    st_r <= st_nxt;
    hn_r <= hn_nxt;
  end

  assign out_valid      = busy_r;
  assign out_word_value = sel_r ? hi_r : lo_r;
  assign out_word_index = sel_r;
  assign out_end_of_run = sel_r;
  assign out_status     = st_r;
  assign out_has_n      = hn_r;

endmodule

`default_nettype wire

FILE: design/b24k_chk.sv
// port-level checker for the base-24 key encoder, bound to the top level
// depends on b24k_pkg and base24_key_text_to_binary_macros.svh
`default_nettype none
`include "base24_key_text_to_binary_macros.svh"

module b24k_chk
  import b24k_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_word_value,
  input wire logic        out_word_index,
  input wire logic        out_end_of_run,
  input wire logic        out_status,
  input wire logic        out_has_n
);

  // stalled result holds
  `B24K_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word_value) && $stable(out_word_index))

  // the upper word follows the lower word straight away
  `B24K_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && out_ready && !out_word_index, out_valid && out_word_index)

  // end of run marks exactly the upper word
  `B24K_ASSERT_NOW(a_end_on_upper, clk, rst_n, out_valid, out_end_of_run == out_word_index)

  // n marking only on a valid key, and it sets the flag bit in byte 14
  `B24K_ASSERT_NOW(a_n_valid_only, clk, rst_n, out_valid && out_has_n, !out_status)
  `B24K_ASSERT_NOW(a_n_flag_set, clk, rst_n, out_valid && out_word_index && out_has_n, out_word_value[N_FLAG_BIT])

endmodule

bind base24_key_text_to_binary b24k_chk u_b24k_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_word_value (out_word_value),
  .out_word_index (out_word_index),
  .out_end_of_run (out_end_of_run),
  .out_status     (out_status),
  .out_has_n      (out_has_n)
);

`default_nettype wire
